// ----- src/qdt_pkg.sv -----
// Package for the quoted delimiter tokenizer: register indexes, reset values,
// field widths and the word and nesting limits. No dependencies.
`default_nettype none

package qdt_pkg;

  // Field widths fixed by the item format.
  localparam int CHAR_W  = 8;
  localparam int WORD_W  = 6;
  localparam int LEN_W   = 8;
  localparam int DEPTH_W = 4;

  // Default string length limit, handed to the top level parameter.
  localparam int MAX_CHARS_DEF = 256;

  // Word slot and nesting limits, clamped to what the counters can hold.
  localparam int MAX_WORDS = 64;
  localparam int MAX_NEST  = 8;
  localparam int WORD_LIM_I = (MAX_WORDS - 1 > 63) ? 63 : MAX_WORDS - 1;
  localparam int NEST_LIM_I = (MAX_NEST > 15) ? 15 : MAX_NEST;
  localparam logic [WORD_W-1:0]  WORD_LIM = WORD_LIM_I[WORD_W-1:0];
  localparam logic [DEPTH_W-1:0] NEST_LIM = NEST_LIM_I[DEPTH_W-1:0];
  localparam logic [LEN_W-1:0]   LEN_MAX  = '1;

  // Configuration register map.
  localparam int NUM_REGS = 8;
  localparam int NUM_DELIMS = 6;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DELIM_A     = 3'd0,
    REG_DELIM_B     = 3'd1,
    REG_DELIM_C     = 3'd2,
    REG_DELIM_D     = 3'd3,
    REG_DELIM_E     = 3'd4,
    REG_DELIM_F     = 3'd5,
    REG_QUOTE_OPEN  = 3'd6,
    REG_QUOTE_CLOSE = 3'd7
  } reg_idx_t;

  typedef logic [CHAR_W-1:0] char_t;

  // Reset values: newline, comma, equals, parentheses and double quotes.
  localparam char_t CFG_RESET [NUM_REGS] = '{
    8'd10, 8'd44, 8'd61, 8'd40, 8'd44, 8'd41, 8'd34, 8'd34
  };

endpackage

`default_nettype wire

// ----- src/quoted_delimiter_tokenizer.sv -----
// Quoted delimiter tokenizer, top level; uses qdt_pkg.
// An accepted item's result sits in the output register from the next cycle.
// Throughput: one item per cycle unless out_stall holds a result; the single result
// register sets it; an item is taken while a waiting result leaves this cycle.
// Reset (rst_n, synchronous): registers return to defaults, word state to word 1.
`default_nettype none

module quoted_delimiter_tokenizer #(
  parameter int MAX_CHARS = qdt_pkg::MAX_CHARS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [qdt_pkg::CHAR_W-1:0]   in_char_value,
  input  wire logic                         in_last_char,
  // Result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_char_valid,
  output logic [qdt_pkg::WORD_W-1:0]        out_word_index,
  output logic [qdt_pkg::CHAR_W-1:0]        out_char_out,
  output logic [qdt_pkg::LEN_W-1:0]         out_pos_in_word,
  output logic                              out_done_res,
  output logic [qdt_pkg::WORD_W-1:0]        out_word_count,
  output logic                              out_overflow,
  // Configuration write channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [qdt_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [qdt_pkg::CHAR_W-1:0]   cfg_data
);

  localparam int CPW = $clog2(MAX_CHARS);
  localparam logic [CPW-1:0] POS_LIM = CPW'(MAX_CHARS - 1);
  localparam int WW = qdt_pkg::WORD_W;
  localparam int LW = qdt_pkg::LEN_W;
  localparam int DW = qdt_pkg::DEPTH_W;

  // Configuration registers.
  qdt_pkg::char_t cfg_r [qdt_pkg::NUM_REGS];

  // Tokenizer state.
  logic [WW-1:0]  cur_word_r, cur_word_nxt;
  logic [LW-1:0]  cur_len_r, cur_len_nxt;
  logic [DW-1:0]  nest_depth_r, nest_depth_nxt;
  logic [CPW-1:0] char_pos_r, char_pos_nxt;
  logic           ovf_r, ovf_nxt;

  // Result register.
  logic           out_valid_r;
  logic           char_valid_r, char_valid_nxt;
  logic [WW-1:0]  word_index_r, word_index_nxt;
  logic [7:0]     char_out_r, char_out_nxt;
  logic [LW-1:0]  pos_r, pos_nxt;
  logic           done_r;
  logic [WW-1:0]  count_r, count_nxt;
  logic           overflow_r;

  logic in_acc;
  logic has_result;

  // Decode signals.
  logic room, is_qo, is_qc, is_quote, opening, delim_hit, is_delim, start_word;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < qdt_pkg::NUM_REGS; i++) begin
        cfg_r[i] <= qdt_pkg::CFG_RESET[i];
      end
    end else if (cfg_valid && cfg_ready) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // Character classification against the quote pair and the delimiters.
  always_comb begin
    room     = char_pos_r < POS_LIM;
    is_qo    = in_char_value == cfg_r[qdt_pkg::REG_QUOTE_OPEN];
    is_qc    = in_char_value == cfg_r[qdt_pkg::REG_QUOTE_CLOSE];
    is_quote = is_qo | is_qc;
    // With one shared quote character it opens only at depth zero.
    if (cfg_r[qdt_pkg::REG_QUOTE_OPEN] == cfg_r[qdt_pkg::REG_QUOTE_CLOSE]) begin
      opening = is_qo & (nest_depth_r == '0);
    end else begin
      opening = is_qo;
    end
    delim_hit = 1'b0;
    for (int i = 0; i < qdt_pkg::NUM_DELIMS; i++) begin
      delim_hit = delim_hit | (in_char_value == cfg_r[i]);
    end
    is_delim = delim_hit & (nest_depth_r == '0);
    // With room, a closing quote starts a word; others only after a non-empty one.
    start_word = room & ((is_quote & ~opening) |
                         ((cur_len_r != '0) & ((is_quote & opening) | is_delim)));
  end

  // Next state and result payload for one item.
  always_comb begin
    cur_word_nxt   = cur_word_r;
    cur_len_nxt    = cur_len_r;
    nest_depth_nxt = nest_depth_r;
    char_pos_nxt   = char_pos_r;
    ovf_nxt        = ovf_r;
    char_valid_nxt = 1'b0;
    word_index_nxt = '0;
    char_out_nxt   = '0;
    pos_nxt        = '0;

    if (room) begin
      char_pos_nxt = char_pos_r + 1'b1;
      if (is_quote) begin
        if (opening) begin
          if (nest_depth_r < qdt_pkg::NEST_LIM) begin
            nest_depth_nxt = nest_depth_r + 1'b1;
          end
        end else if (nest_depth_r != '0) begin
          nest_depth_nxt = nest_depth_r - 1'b1;
        end
      end else if (!is_delim) begin
        char_valid_nxt = 1'b1;
        word_index_nxt = cur_word_r;
        char_out_nxt   = in_char_value;
        pos_nxt        = cur_len_r;
        if (cur_len_r != qdt_pkg::LEN_MAX) begin
          cur_len_nxt = cur_len_r + 1'b1;
        end
      end
    end

    // Moving to a new word saturates at the last slot and flags overflow.
    if (start_word) begin
      if (cur_word_r >= qdt_pkg::WORD_LIM) begin
        ovf_nxt = 1'b1;
      end else begin
        cur_word_nxt = cur_word_r + 1'b1;
        cur_len_nxt  = '0;
      end
    end

    // The word count leaves out a trailing empty word.
    count_nxt = '0;
    if (in_last_char) begin
      count_nxt = cur_word_nxt - WW'(cur_len_nxt == '0);
    end
    has_result = char_valid_nxt | in_last_char;
  end

  // State update; the last character of a string clears it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_word_r   <= WW'(1);
      cur_len_r    <= '0;
      nest_depth_r <= '0;
      char_pos_r   <= '0;
      ovf_r        <= 1'b0;
    end else if (in_acc) begin
      if (in_last_char) begin
        cur_word_r   <= WW'(1);
        cur_len_r    <= '0;
        nest_depth_r <= '0;
        char_pos_r   <= '0;
        ovf_r        <= 1'b0;
      end else begin
        cur_word_r   <= cur_word_nxt;
        cur_len_r    <= cur_len_nxt;
        nest_depth_r <= nest_depth_nxt;
        char_pos_r   <= char_pos_nxt;
        ovf_r        <= ovf_nxt;
      end
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && has_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (in_acc && has_result) begin
      char_valid_r <= char_valid_nxt;
      word_index_r <= word_index_nxt;
      char_out_r   <= char_out_nxt;
      pos_r        <= pos_nxt;
      done_r       <= in_last_char;
      count_r      <= count_nxt;
      overflow_r   <= ovf_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_valid  = char_valid_r;
  assign out_word_index  = word_index_r;
  assign out_char_out    = char_out_r;
  assign out_pos_in_word = pos_r;
  assign out_done_res    = done_r;
  assign out_word_count  = count_r;
  assign out_overflow    = overflow_r;

  // A string's last character leaves the word state at its start values.
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_char) |=>
      (cur_word_r == WW'(1) && cur_len_r == '0 && nest_depth_r == '0 && !ovf_r))
    else $error("word state not cleared after last character");

  // Quote nesting never passes its limit.
  a_nest_limit: assert property (@(posedge clk) disable iff (!rst_n)
    nest_depth_r <= qdt_pkg::NEST_LIM)
    else $error("nesting depth above limit");

  // A result either carries a character or ends a string.
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_char_valid) |-> out_done_res)
    else $error("empty result that does not end a string");

  // Appended characters always go to a word slot from one upward.
  a_word_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_char_valid) |-> (out_word_index != '0))
    else $error("character reported in word slot zero");

endmodule

`default_nettype wire

// ----- test/tb_quoted_delimiter_tokenizer.sv -----
// Testbench for quoted_delimiter_tokenizer: directed strings, random register settings,
// word overflow and over-length strings, checked against a cycle-free predictor.
// Depends on qdt_pkg and the quoted_delimiter_tokenizer RTL only.

module tb_quoted_delimiter_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CHARS      = qdt_pkg::MAX_CHARS_DEF;
  localparam int WORD_LIMIT     = 63;   // last word slot the index may reach
  localparam int NEST_LIMIT     = 8;    // deepest quote nesting that is counted
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REPORT_LIMIT   = 10;

  localparam qdt_pkg::char_t DEFAULT_REGS [qdt_pkg::NUM_REGS] = '{
    8'd10, 8'd44, 8'd61, 8'd40, 8'd44, 8'd41, 8'd34, 8'd34
  };

  typedef qdt_pkg::char_t text_t[$];

  typedef struct packed {
    logic                       char_valid;
    logic [qdt_pkg::WORD_W-1:0] word_index;
    qdt_pkg::char_t             char_out;
    logic [qdt_pkg::LEN_W-1:0]  pos_in_word;
    logic                       done_res;
    logic [qdt_pkg::WORD_W-1:0] word_count;
    logic                       overflow;
  } token_t;

  // Clock, reset and block ports.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  qdt_pkg::char_t in_char_value = '0;
  logic in_last_char = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_char_valid;
  logic [qdt_pkg::WORD_W-1:0] out_word_index;
  qdt_pkg::char_t out_char_out;
  logic [qdt_pkg::LEN_W-1:0] out_pos_in_word;
  logic out_done_res;
  logic [qdt_pkg::WORD_W-1:0] out_word_count;
  logic out_overflow;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  qdt_pkg::reg_idx_t cfg_index = qdt_pkg::REG_DELIM_A;
  qdt_pkg::char_t cfg_data = '0;

  // Predictor state: register copy and the tokenizer's running counters.
  qdt_pkg::char_t cfg_regs [qdt_pkg::NUM_REGS];
  int unsigned tok_word;
  int unsigned tok_len;
  int unsigned tok_depth;
  int unsigned tok_pos;
  logic tok_ovf;
  token_t expected_tokens[$];

  bit idle_on = 1'b1;
  int items_sent = 0;
  int strings_sent = 0;
  int results_checked = 0;
  int settings_loaded = 0;
  int mismatch_count = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  quoted_delimiter_tokenizer #(
    .MAX_CHARS(MAX_CHARS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_value  (in_char_value),
    .in_last_char   (in_last_char),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_valid (out_char_valid),
    .out_word_index (out_word_index),
    .out_char_out   (out_char_out),
    .out_pos_in_word(out_pos_in_word),
    .out_done_res   (out_done_res),
    .out_word_count (out_word_count),
    .out_overflow   (out_overflow),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  function automatic void clear_tokens();
    tok_word  = 1;
    tok_len   = 0;
    tok_depth = 0;
    tok_pos   = 0;
    tok_ovf   = 1'b0;
  endfunction

  // Move to the next word slot, or hold the last slot and flag the overflow.
  function automatic void start_word();
    if (tok_word >= WORD_LIMIT) begin
      tok_ovf = 1'b1;
    end else begin
      tok_word++;
      tok_len = 0;
    end
  endfunction

  // Work out the result, if any, of one accepted character.
  function automatic void tokenize_char(qdt_pkg::char_t ch, logic last);
    token_t r;
    logic opening;
    logic is_delim;
    int unsigned cnt;
    r = '0;
    if (tok_pos < MAX_CHARS - 1) begin
      tok_pos++;
      if (ch == cfg_regs[qdt_pkg::REG_QUOTE_OPEN] ||
          ch == cfg_regs[qdt_pkg::REG_QUOTE_CLOSE]) begin
        opening = (ch == cfg_regs[qdt_pkg::REG_QUOTE_OPEN]);
        // With one quote character, it opens only when no quote is open.
        if (cfg_regs[qdt_pkg::REG_QUOTE_OPEN] == cfg_regs[qdt_pkg::REG_QUOTE_CLOSE])
          opening = opening && (tok_depth == 0);
        if (opening) begin
          if (tok_depth < NEST_LIMIT) tok_depth++;
          if (tok_len != 0) start_word();
        end else begin
          if (tok_depth > 0) tok_depth--;
          start_word();
        end
      end else begin
        is_delim = 1'b0;
        for (int d = 0; d < qdt_pkg::NUM_DELIMS; d++)
          if (cfg_regs[d] == ch) is_delim = 1'b1;
        if (tok_depth > 0) is_delim = 1'b0;
        if (!is_delim) begin
          r.char_valid  = 1'b1;
          r.word_index  = tok_word[qdt_pkg::WORD_W-1:0];
          r.char_out    = ch;
          r.pos_in_word = tok_len[qdt_pkg::LEN_W-1:0];
          if (tok_len < 255) tok_len++;
        end else if (tok_len != 0) begin
          start_word();
        end
      end
    end
    if (r.char_valid || last) begin
      r.overflow = tok_ovf;
      if (last) begin
        cnt = tok_word - ((tok_len == 0) ? 1 : 0);
        r.done_res   = 1'b1;
        r.word_count = cnt[qdt_pkg::WORD_W-1:0];
        clear_tokens();
      end
      expected_tokens.push_back(r);
    end
  endfunction

  function automatic string show_token(token_t r);
    return $sformatf("cv=%0b idx=%0d ch=%02h pos=%0d done=%0b cnt=%0d ovf=%0b",
                     r.char_valid, r.word_index, r.char_out, r.pos_in_word,
                     r.done_res, r.word_count, r.overflow);
  endfunction

  // Draw a character that is likely to matter under the current registers.
  function automatic qdt_pkg::char_t pick_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return qdt_pkg::char_t'($urandom_range(8'h61, 8'h7A));
    if (roll < 75) return cfg_regs[$urandom_range(0, qdt_pkg::NUM_DELIMS - 1)];
    if (roll < 83) return cfg_regs[qdt_pkg::REG_QUOTE_OPEN];
    if (roll < 91) return cfg_regs[qdt_pkg::REG_QUOTE_CLOSE];
    return qdt_pkg::char_t'($urandom_range(1, 255));
  endfunction

  function automatic text_t make_text(int len);
    text_t s;
    for (int k = 0; k < len; k++) s.push_back(pick_char());
    return s;
  endfunction

  // Send one item, holding it until the block takes it.
  task automatic send_char(input qdt_pkg::char_t ch, input logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_char_value <= ch;
    in_last_char  <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    tokenize_char(ch, last);
    items_sent++;
  endtask

  // Stop sending and wait until every expected result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Send a whole string; pause_at names a character to wait before, or -1.
  task automatic send_string(input text_t s, input int pause_at);
    foreach (s[k]) begin
      if (k == pause_at) drain_results();
      send_char(s[k], k == s.size() - 1);
    end
    strings_sent++;
  endtask

  // Write all registers once the block has gone quiet.
  task automatic load_registers(input qdt_pkg::char_t vals [qdt_pkg::NUM_REGS]);
    drain_results();
    for (int r = 0; r < qdt_pkg::NUM_REGS; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= qdt_pkg::reg_idx_t'(r);
      cfg_data  <= vals[r];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      cfg_regs[r] = vals[r];
    end
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  // Short strings for the corner cases, first with reset registers, then extremes.
  task automatic test_directed_cases();
    qdt_pkg::char_t extremes [qdt_pkg::NUM_REGS];
    text_t s;
    s = '{8'h61, 8'h2C, 8'h2C, 8'h63};
    send_string(s, -1);
    // An opening quote after a word, a comma held inside the quotes.
    s = '{8'h61, 8'h22, 8'h2C, 8'h22, 8'h79};
    send_string(s, -1);
    s = '{8'h00, 8'hFF};
    send_string(s, -1);
    // A lone delimiter gives no words; a trailing delimiter leaves an empty word.
    s = '{8'h2C};
    send_string(s, -1);
    s = '{8'h71, 8'h3D};
    send_string(s, -1);
    extremes = '{8'h00, 8'hFF, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'h3C, 8'h3E};
    load_registers(extremes);
    // Closing quote with nothing open, then a delimiter on an empty word.
    s = '{8'h3E, 8'hFF, 8'h6B};
    send_string(s, -1);
    // Nesting beyond the limit, delimiters taken as text inside quotes.
    s = {};
    repeat (NEST_LIMIT + 1) s.push_back(8'h3C);
    s.push_back(8'h7A);
    s.push_back(8'h00);
    s.push_back(8'h3E);
    s.push_back(8'hFF);
    send_string(s, -1);
  endtask

  // Random register settings, each followed by random strings.
  task automatic test_random_settings(input int n_settings, input int items_each);
    qdt_pkg::char_t vals [qdt_pkg::NUM_REGS];
    int start;
    for (int n = 0; n < n_settings; n++) begin
      foreach (vals[r]) vals[r] = qdt_pkg::char_t'($urandom_range(0, 255));
      vals[qdt_pkg::REG_QUOTE_OPEN] = qdt_pkg::char_t'($urandom_range(1, 255));
      if ($urandom_range(0, 1) == 1)
        vals[qdt_pkg::REG_QUOTE_CLOSE] = vals[qdt_pkg::REG_QUOTE_OPEN];
      load_registers(vals);
      start = items_sent;
      // The first string of each setting is held mid-way until all results are out.
      send_string(make_text(24), 12);
      while (items_sent - start < items_each)
        send_string(make_text($urandom_range(1, 30)), -1);
    end
  endtask

  // Exactly the last word slot, then more words than slots with quotes past the limit.
  task automatic test_word_overflow();
    qdt_pkg::char_t seps [3];
    int word_total [2];
    text_t s;
    seps = '{8'h2C, 8'h3D, 8'h0A};
    word_total = '{WORD_LIMIT, WORD_LIMIT + 9};
    load_registers(DEFAULT_REGS);
    foreach (word_total[w]) begin
      s = {};
      for (int k = 0; k < word_total[w]; k++) begin
        if (k != 0) s.push_back(seps[$urandom_range(0, 2)]);
        s.push_back(qdt_pkg::char_t'($urandom_range(8'h61, 8'h7A)));
      end
      if (w == 1) begin
        s.push_back(8'h22);
        s.push_back(8'h78);
        s.push_back(8'h22);
        s.push_back(8'h79);
      end
      send_string(s, -1);
    end
  endtask

  // Strings longer than the character limit: one long word, one mixed.
  task automatic test_long_strings();
    text_t s;
    s = {};
    repeat (MAX_CHARS + 6) s.push_back(qdt_pkg::char_t'($urandom_range(8'h41, 8'h5A)));
    send_string(s, -1);
    send_string(make_text(MAX_CHARS + 2), -1);
  endtask

  // Back-to-back traffic with no gaps and no stalls.
  task automatic test_steady_stream(input int n_items);
    int start;
    idle_on = 1'b0;
    load_registers(DEFAULT_REGS);
    start = items_sent;
    while (items_sent - start < n_items)
      send_string(make_text($urandom_range(1, 30)), -1);
  endtask

  // Check each result taken from the block and draw the stall pattern.
  always @(posedge clk) begin : result_check
    token_t got;
    token_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{out_char_valid, out_word_index, out_char_out, out_pos_in_word,
              out_done_res, out_word_count, out_overflow};
      if (expected_tokens.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("Unexpected result at %0t: %s", $time, show_token(got));
      end else begin
        want = expected_tokens.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("Mismatch at %0t", $time);
            $display("  expected %s", show_token(want));
            $display("  actual   %s", show_token(got));
          end
        end
      end
    end
    if (!idle_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // End the run if no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    clear_tokens();
    cfg_regs = DEFAULT_REGS;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_settings(4, 110);
    test_word_overflow();
    test_long_strings();
    test_steady_stream(150);
    drain_results();
    $display("Sent %0d characters in %0d strings under %0d register settings.",
             items_sent, strings_sent, settings_loaded + 1);
    $display("Checked %0d results, %0d mismatched.", results_checked, mismatch_count);
    if (mismatch_count == 0 && expected_tokens.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
